// ----- design/uart_receiver_with_fifo_defines.svh -----
// Assertion macros shared by the UART receiver modules
`ifndef UART_RECEIVER_WITH_FIFO_DEFINES_SVH
`define UART_RECEIVER_WITH_FIFO_DEFINES_SVH

`ifndef ASSERT_OFF
`define URF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define URF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define URF_ASSERT(lbl, clk, rst, prop, msg)
`define URF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/urf_pkg.sv -----
// Types, constants and helpers for the UART receiver with receive buffer
package urf_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = PTR_W + 1;
   localparam int DELAY_W      = 12;
   localparam int BYTE_W       = 8;
   localparam int BIT_IDX_W    = 3;
   localparam int AVAIL_W      = 6;
   localparam int CSR_ADDR_W   = 2;

   localparam logic [DELAY_W-1:0] CENTER_DELAY_RST = 12'd8;
   localparam logic [DELAY_W-1:0] BIT_DELAY_RST    = 12'd16;
   localparam logic [DELAY_W-1:0] STOP_DELAY_RST   = 12'd16;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic [1:0] {
      ACT_TICK,
      ACT_POP,
      ACT_FLUSH,
      ACT_CLR_OVF
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CENTER,
      PH_DATA,
      PH_STOP
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CENTER_DELAY,
      CSR_BIT_DELAY,
      CSR_STOP_DELAY
   } csr_index_type;

   typedef struct packed {
      logic [DELAY_W-1:0] center_delay;
      logic [DELAY_W-1:0] bit_delay;
      logic [DELAY_W-1:0] stop_delay;
   } csr_type;

   // Frame end report from the receiver to the buffer
   typedef struct packed {
      logic              done;
      logic              stop_low;
      logic [BYTE_W-1:0] rx_byte;
   } frame_type;

   // Buffer status seen by one transfer
   typedef struct packed {
      logic [BYTE_W-1:0]  head_byte;
      logic               head_valid;
      logic [AVAIL_W-1:0] available;
      logic               overflow;
   } ring_status_type;

   // Advance a ring pointer with wrap at the buffer depth
   function automatic ptr_type ring_next(input ptr_type p);
      return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

// ----- design/urf_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module urf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/urf_rx.sv -----
// UART 8N1 receive state machine driven by line-sample transfers
`include "uart_receiver_with_fifo_defines.svh"

module urf_rx (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_en,
   input  logic               rx_level,
   input  urf_pkg::csr_type   cfg,
   output urf_pkg::frame_type frame
);

   urf_pkg::phase_type                  phase_ff, phase_in;
   logic [urf_pkg::DELAY_W-1:0]         tick_count_ff, tick_count_in;
   logic [urf_pkg::BIT_IDX_W-1:0]       bit_index_ff, bit_index_in;
   logic [urf_pkg::BYTE_W-1:0]          shift_ff, shift_in;
   logic [urf_pkg::DELAY_W-1:0]         cnt_inc;
   logic [urf_pkg::DELAY_W-1:0]         delay_sel;
   logic                                wait_hit;
   logic                                last_bit;

   // Pick the delay of the current wait and compare the advanced count
   always_comb begin
      cnt_inc = tick_count_ff + 1'b1;
      case (phase_ff)
         urf_pkg::PH_CENTER: delay_sel = cfg.center_delay;
         urf_pkg::PH_DATA:   delay_sel = cfg.bit_delay;
         default:            delay_sel = cfg.stop_delay;
      endcase
      wait_hit = (cnt_inc == delay_sel);
      last_bit = (bit_index_ff == urf_pkg::BIT_IDX_W'(urf_pkg::BYTE_W - 1));
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (tick_en) begin
         unique case (phase_ff)
            urf_pkg::PH_IDLE: begin
               if (!rx_level) begin
                  phase_in = (cfg.center_delay == '0) ? urf_pkg::PH_DATA
                                                      : urf_pkg::PH_CENTER;
               end
            end
            urf_pkg::PH_CENTER: begin
               if (wait_hit) phase_in = urf_pkg::PH_DATA;
            end
            urf_pkg::PH_DATA: begin
               if (wait_hit && last_bit) phase_in = urf_pkg::PH_STOP;
            end
            urf_pkg::PH_STOP: begin
               if (wait_hit) phase_in = urf_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Counter, bit index, shift register and frame report
   always_comb begin
      tick_count_in  = tick_count_ff;
      bit_index_in   = bit_index_ff;
      shift_in       = shift_ff;
      frame.done     = 1'b0;
      frame.stop_low = 1'b0;
      frame.rx_byte  = shift_ff;
      if (tick_en) begin
         unique case (phase_ff)
            urf_pkg::PH_IDLE: begin
               if (!rx_level) begin
                  tick_count_in = '0;
                  bit_index_in  = '0;
                  shift_in      = '0;
               end
            end
            urf_pkg::PH_CENTER: begin
               tick_count_in = wait_hit ? '0 : cnt_inc;
            end
            urf_pkg::PH_DATA: begin
               tick_count_in = wait_hit ? '0 : cnt_inc;
               if (wait_hit) begin
                  shift_in[bit_index_ff] = rx_level;
                  bit_index_in = last_bit ? '0 : bit_index_ff + 1'b1;
               end
            end
            urf_pkg::PH_STOP: begin
               tick_count_in  = wait_hit ? '0 : cnt_inc;
               frame.done     = wait_hit;
               frame.stop_low = wait_hit && !rx_level;
            end
         endcase
      end
   end

   // Hold receiver state between line samples
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= urf_pkg::PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
      end
   end

   `URF_ASSERT_IMPL(a_done_in_stop, clock, reset, frame.done, phase_ff == urf_pkg::PH_STOP, "frame end outside stop phase")
   `URF_ASSERT_IMPL(a_idx_only_data, clock, reset, phase_ff != urf_pkg::PH_DATA, bit_index_ff == '0, "bit index left nonzero outside data phase")

endmodule

// ----- design/urf_ring.sv -----
// Receive ring buffer: pointers, overflow flag, storage and head-byte bypass
`include "uart_receiver_with_fifo_defines.svh"

module urf_ring (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_en,
   input  urf_pkg::action_type      action,
   input  urf_pkg::frame_type       frame,
   output urf_pkg::ring_status_type status
);

   urf_pkg::ptr_type              head_ff, head_in;
   urf_pkg::ptr_type              tail_ff, tail_in;
   urf_pkg::ptr_type              tail_next;
   logic                          ovf_ff, ovf_in;
   logic                          fwd_ff, fwd_in;
   logic [urf_pkg::BYTE_W-1:0]    fwd_data_ff;
   logic [urf_pkg::BYTE_W-1:0]    rd_data;
   logic [urf_pkg::CNT_W-1:0]     cnt_in;
   logic                          full;
   logic                          wr_en;
   logic                          store_try;

   assign tail_next = urf_pkg::ring_next(tail_ff);
   assign full      = (tail_next == head_ff);
   assign store_try = op_en && (action == urf_pkg::ACT_TICK) && frame.done;
   assign wr_en     = store_try && !full;

   // Update pointers and overflow flag for the accepted action
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      ovf_in  = ovf_ff;
      if (op_en) begin
         unique case (action)
            urf_pkg::ACT_TICK: begin
               if (frame.done) begin
                  if (full) ovf_in = 1'b1;
                  else      tail_in = tail_next;
               end
            end
            urf_pkg::ACT_POP: begin
               if (head_ff != tail_ff) head_in = urf_pkg::ring_next(head_ff);
            end
            urf_pkg::ACT_FLUSH: begin
               head_in = '0;
               tail_in = '0;
            end
            urf_pkg::ACT_CLR_OVF: begin
               ovf_in = 1'b0;
            end
         endcase
      end
   end

   // Fill level after the action
   always_comb begin
      if (tail_in >= head_in) begin
         cnt_in = {1'b0, tail_in} - {1'b0, head_in};
      end else begin
         cnt_in = {1'b0, tail_in} + urf_pkg::CNT_W'(urf_pkg::BUFFER_DEPTH) - {1'b0, head_in};
      end
   end

   // Forward a byte written at the address being read in the same cycle
   assign fwd_in = wr_en && (tail_ff == head_in);

   // Report status seen before the action, fill level after it
   always_comb begin
      status.head_valid = (head_ff != tail_ff);
      status.head_byte  = status.head_valid ? (fwd_ff ? fwd_data_ff : rd_data) : '0;
      status.available  = urf_pkg::AVAIL_W'(cnt_in);
      status.overflow   = ovf_ff;
   end

   // Hold pointers and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         ovf_ff  <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         ovf_ff  <= ovf_in;
         fwd_ff  <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= frame.rx_byte;
   end

   // Storage, read always at the head pointer of the next cycle
   urf_ram #(
      .WIDTH(urf_pkg::BYTE_W),
      .DEPTH(urf_pkg::BUFFER_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(frame.rx_byte),
      .rd_addr(head_in),
      .rd_data(rd_data)
   );

   `URF_ASSERT_IMPL(a_ovf_rise_on_full, clock, reset, $rose(ovf_ff), $past(store_try && full), "overflow set without a dropped byte")
   `URF_ASSERT_IMPL(a_tail_moves_on_store, clock, reset, tail_ff != $past(tail_ff), $past(wr_en) || $past(op_en && action == urf_pkg::ACT_FLUSH), "tail moved without a store or flush")

endmodule

// ----- design/uart_receiver_with_fifo.sv -----
// Top level: UART 8N1 receiver with receive ring buffer and result register
//
// Channel   Direction  Accepted when           Contents
// req_      in         req_tvalid & req_tready action, RX line sample
// rsp_      out        rsp_tvalid & rsp_tready head byte, fill level, flags
// csr_      in         csr_we                  center, bit and stop delays
//
// One transfer per clock while results are taken; each result is registered and valid in the cycle after
// its request transfer. The request's own cycle holds the receiver counter compare and the
// buffer pointer update, which also addresses the storage read for the next head.
// Reset is synchronous; it clears the receiver and the pointers with no pass over
// the storage.
// A stalled result holds in the result register; req_tready falls only while
// that register is full and not being taken.
`include "uart_receiver_with_fifo_defines.svh"

module uart_receiver_with_fifo (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [0] rx_level, [7:1] zero
   input  logic [1:0]                        req_tuser,  // [1:0] action
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // [7:0] data, [8] data_valid,
                                                         // [14:9] available, [15] overflow,
                                                         // [16] frame_done, [17] stop_low,
                                                         // [23:18] zero
   // configuration write port
   input  logic                              csr_we,
   input  logic [urf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [urf_pkg::DELAY_W-1:0]       csr_wdata
);

   urf_pkg::csr_type          cfg_ff;
   urf_pkg::action_type       action;
   urf_pkg::frame_type        frame;
   urf_pkg::ring_status_type  status;
   logic                      accept;
   logic                      tick_en;
   logic                      rsp_valid_ff;
   logic [23:0]               rsp_data_ff, rsp_data_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_delay <= urf_pkg::CENTER_DELAY_RST;
         cfg_ff.bit_delay    <= urf_pkg::BIT_DELAY_RST;
         cfg_ff.stop_delay   <= urf_pkg::STOP_DELAY_RST;
      end else if (csr_we) begin
         unique case (urf_pkg::csr_index_type'(csr_addr))
            urf_pkg::CSR_CENTER_DELAY: cfg_ff.center_delay <= csr_wdata;
            urf_pkg::CSR_BIT_DELAY:    cfg_ff.bit_delay    <= csr_wdata;
            urf_pkg::CSR_STOP_DELAY:   cfg_ff.stop_delay   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accept a request whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign action     = urf_pkg::action_type'(req_tuser);
   assign tick_en    = accept && (action == urf_pkg::ACT_TICK);

   urf_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .rx_level(req_tdata[0]),
      .cfg     (cfg_ff),
      .frame   (frame)
   );

   urf_ring u_ring (
      .clock (clock),
      .reset (reset),
      .op_en (accept),
      .action(action),
      .frame (frame),
      .status(status)
   );

   // Pack the result
   assign rsp_data_in = {6'b0, frame.stop_low, frame.done, status.overflow,
                         status.available, status.head_valid, status.head_byte};

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
